// ===== rtl/core/ptsu_pkg.sv =====
`timescale 1ns / 1ps
package ptsu_pkg;

  localparam int NUM_TASKS  = 16;
  localparam int NUM_LEVELS = 32;

  localparam int TASK_W  = $clog2(NUM_TASKS);
  localparam int LEVEL_W = $clog2(NUM_LEVELS);
  localparam int CNT_W   = $clog2(NUM_TASKS + 1);

  localparam logic [7:0] LOCK_MAX    = 8'd255;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  localparam logic [2:0] CMD_MAKE_READY = 3'd0;
  localparam logic [2:0] CMD_UNREADY    = 3'd1;
  localparam logic [2:0] CMD_DELAY      = 3'd2;
  localparam logic [2:0] CMD_WAKEUP     = 3'd3;
  localparam logic [2:0] CMD_TICK       = 3'd4;
  localparam logic [2:0] CMD_LOCK       = 3'd5;
  localparam logic [2:0] CMD_UNLOCK     = 3'd6;
  localparam logic [2:0] CMD_SCHEDULE   = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  task_id;
    logic [4:0]  task_priority;
    logic [31:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic        switch_now;
    logic [3:0]  next_task;
    logic [4:0]  woke_count;
    logic [7:0]  lock_level;
    logic        bad_request;
  } rsp_t;

endpackage

// ===== rtl/core/ptsu_ram.sv =====
`timescale 1ns / 1ps
module ptsu_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/priority_task_scheduler_unit.sv =====
`timescale 1ns / 1ps
// Priority task scheduler: one command transaction in, one result transaction out. Per-task
// and per-level state (task level, ready links, delay counts, slices, level head, tail and
// count) lives in single-read-port RAMs, and a sequencer walks them. Requests stall while a
// command is in progress. Make_ready first unlinks a task that was already ready from its
// level, then pushes it at the level head; unready walks the level list to unlink the task.
// A repeated delay, and a wakeup, compact the delay order. A tick walks the delayed tasks,
// wakes those whose count reaches zero (unlinking one that was already ready, then pushing
// it at its level head), and rotates the running task's level, head to tail, when the slice
// runs out. The next command is accepted while a result still waits at the output register.
module priority_task_scheduler_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ptsu_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ptsu_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data
);

  localparam int TW = ptsu_pkg::TASK_W;
  localparam int LW = ptsu_pkg::LEVEL_W;
  localparam int CW = ptsu_pkg::CNT_W;
  localparam int NT = ptsu_pkg::NUM_TASKS;
  localparam int NL = ptsu_pkg::NUM_LEVELS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MR0, ST_MR1, ST_MR2, ST_UR0, ST_UR1, ST_DL0, ST_DR,
    ST_TK0, ST_TK1, ST_TKP, ST_SL0, ST_SL1, ST_RO0, ST_RO1, ST_RO2,
    ST_RM0, ST_RM1, ST_RMW, ST_RMW2, ST_RMDEC, ST_PH0, ST_PH1, ST_PT0,
    ST_PT1, ST_FIN0, ST_FIN1, ST_OUT
  } state_t;

  state_t st, rm_ret, ps_ret, acc_st;

  logic [7:0]    slice_reload;
  logic [NL-1:0] ready_bitmap;
  logic [NT-1:0] is_ready, delayed_mask, slc_vld;
  logic [TW-1:0] dly_order [NT];
  logic [CW-1:0] dly_num, i, k, j, cn, woke;
  logic [TW-1:0] running, tt, p, lt, tl, c_tid;
  logic [LW-1:0] lv, c_lv, enc;
  logic [31:0]   c_dly, tick_total;
  logic [7:0]    lock_depth;
  logic          sched, bad, app;
  logic          acc_bad, acc_sched;
  ptsu_pkg::rsp_t res;

  // ram ports
  logic          hd_we, tl_we, ct_we, lk_we, lv_we, dl_we, sl_we;
  logic [LW-1:0] hd_raddr, tl_raddr, ct_raddr;
  logic [LW-1:0] hd_waddr, tl_waddr, ct_waddr;
  logic [TW-1:0] lk_raddr, lv_raddr, dl_raddr, sl_raddr;
  logic [TW-1:0] lk_waddr, lv_waddr, dl_waddr, sl_waddr;
  logic [TW-1:0] hd_wdata, tl_wdata, lk_wdata;
  logic [TW-1:0] rd_head, rd_tail, rd_link;
  logic [CW-1:0] ct_wdata, rd_cnt;
  logic [LW-1:0] lv_wdata, rd_lev;
  logic [31:0]   dl_wdata, rd_dly;
  logic [7:0]    sl_wdata, rd_slc;

  logic [CW-1:0] cn0;
  logic [31:0]   dv;
  logic [7:0]    s1, reload_eff;
  logic [TW-1:0] nt, ord_i;
  logic          tid_bad, sched_sw;
  logic [LW-1:0] pri_sat;

  ptsu_ram #(.W(TW), .D(NL)) u_head (.clk(clk), .we(hd_we), .waddr(hd_waddr),
    .wdata(hd_wdata), .raddr(hd_raddr), .rdata(rd_head));
  ptsu_ram #(.W(TW), .D(NL)) u_tail (.clk(clk), .we(tl_we), .waddr(tl_waddr),
    .wdata(tl_wdata), .raddr(tl_raddr), .rdata(rd_tail));
  ptsu_ram #(.W(CW), .D(NL)) u_cnt (.clk(clk), .we(ct_we), .waddr(ct_waddr),
    .wdata(ct_wdata), .raddr(ct_raddr), .rdata(rd_cnt));
  ptsu_ram #(.W(TW), .D(NT)) u_link (.clk(clk), .we(lk_we), .waddr(lk_waddr),
    .wdata(lk_wdata), .raddr(lk_raddr), .rdata(rd_link));
  ptsu_ram #(.W(LW), .D(NT)) u_lev (.clk(clk), .we(lv_we), .waddr(lv_waddr),
    .wdata(lv_wdata), .raddr(lv_raddr), .rdata(rd_lev));
  ptsu_ram #(.W(32), .D(NT)) u_dly (.clk(clk), .we(dl_we), .waddr(dl_waddr),
    .wdata(dl_wdata), .raddr(dl_raddr), .rdata(rd_dly));
  ptsu_ram #(.W(8), .D(NT)) u_slc (.clk(clk), .we(sl_we), .waddr(sl_waddr),
    .wdata(sl_wdata), .raddr(sl_raddr), .rdata(rd_slc));

  assign req_stall  = (st != ST_IDLE);
  assign ord_i      = dly_order[i[TW-1:0]];
  assign cn0        = ready_bitmap[lv] ? rd_cnt : '0;
  assign dv         = rd_dly - 32'd1;
  assign s1         = (slc_vld[running] ? rd_slc : ptsu_pkg::SLICE_RESET) - 8'd1;
  assign reload_eff = (slice_reload == 8'd0) ? 8'd1 : slice_reload;
  assign nt         = (|ready_bitmap) ? rd_head : running;
  assign sched_sw   = sched && (lock_depth == 8'd0) && (|ready_bitmap) && (nt != running);
  assign tid_bad    = (req.cmd <= ptsu_pkg::CMD_WAKEUP) && (32'(req.task_id) >= NT);
  assign pri_sat    = (32'(req.task_priority) >= NL) ? LW'(NL - 1) : LW'(req.task_priority);

  // lowest-numbered ready level
  always_comb begin
    enc = '0;
    for (int l = NL - 1; l >= 0; l--) begin
      if (ready_bitmap[l]) begin
        enc = LW'(l);
      end
    end
  end

  // decode of an accepted command
  always_comb begin
    acc_st    = ST_FIN0;
    acc_bad   = tid_bad;
    acc_sched = 1'b0;
    if (!tid_bad) begin
      case (req.cmd)
        ptsu_pkg::CMD_MAKE_READY: begin
          acc_st = is_ready[TW'(req.task_id)] ? ST_MR0 : ST_MR2;
        end
        ptsu_pkg::CMD_UNREADY: begin
          if (is_ready[TW'(req.task_id)]) begin
            acc_st = ST_UR0;
          end else begin
            acc_bad = 1'b1;
          end
        end
        ptsu_pkg::CMD_DELAY: acc_st = ST_DL0;
        ptsu_pkg::CMD_WAKEUP: begin
          if (delayed_mask[TW'(req.task_id)]) begin
            acc_st = ST_DR;
          end else begin
            acc_bad = 1'b1;
          end
        end
        ptsu_pkg::CMD_TICK: acc_st = ST_TK0;
        ptsu_pkg::CMD_LOCK: ;
        ptsu_pkg::CMD_UNLOCK: acc_sched = (lock_depth == 8'd1);
        default: acc_sched = 1'b1;
      endcase
    end
  end

  // read addresses
  always_comb begin
    hd_raddr = (st == ST_FIN0) ? enc : lv;
    tl_raddr = lv;
    ct_raddr = lv;
    lk_raddr = (st == ST_RMW) ? p : tt;
    dl_raddr = ord_i;
    sl_raddr = running;
    case (st)
      ST_MR0, ST_UR0: lv_raddr = c_tid;
      ST_TK0:         lv_raddr = ord_i;
      default:        lv_raddr = running;
    endcase
  end

  // write ports
  always_comb begin
    hd_we = 1'b0; hd_waddr = lv; hd_wdata = tt;
    tl_we = 1'b0; tl_waddr = lv; tl_wdata = tt;
    ct_we = 1'b0; ct_waddr = lv; ct_wdata = cn0 + CW'(1);
    lk_we = 1'b0; lk_waddr = tt; lk_wdata = rd_head;
    lv_we = 1'b0; lv_waddr = c_tid; lv_wdata = c_lv;
    dl_we = 1'b0; dl_waddr = tt; dl_wdata = dv;
    sl_we = 1'b0; sl_waddr = running; sl_wdata = (s1 == 8'd0) ? reload_eff : s1;
    case (st)
      ST_RM1: begin
        if (rd_head == tt) begin
          hd_we    = 1'b1;
          hd_wdata = rd_link;
        end
      end
      ST_RMW2: begin
        if (rd_link == tt) begin
          lk_we    = 1'b1;
          lk_waddr = p;
          lk_wdata = lt;
          tl_we    = (tl == tt);
          tl_wdata = p;
        end
      end
      ST_RMDEC: begin
        ct_we    = 1'b1;
        ct_wdata = cn - CW'(1);
      end
      ST_PH1: begin
        lk_we = 1'b1;
        hd_we = 1'b1;
        tl_we = (cn0 == '0);
        ct_we = 1'b1;
      end
      ST_PT1: begin
        hd_we    = (cn0 == '0);
        lk_we    = (cn0 != '0);
        lk_waddr = rd_tail;
        lk_wdata = tt;
        tl_we    = 1'b1;
        ct_we    = 1'b1;
      end
      ST_MR2: lv_we = 1'b1;
      ST_DL0: begin
        dl_we    = 1'b1;
        dl_waddr = c_tid;
        dl_wdata = (c_dly == 32'd0) ? 32'd1 : c_dly;
      end
      ST_TK1: dl_we = 1'b1;
      ST_SL1: sl_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      slice_reload <= ptsu_pkg::SLICE_RESET;
      ready_bitmap <= '0;
      is_ready     <= '0;
      delayed_mask <= '0;
      slc_vld      <= '0;
      dly_num      <= '0;
      running      <= '0;
      lock_depth   <= '0;
      tick_total   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slice_reload <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && (st != ST_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (req_valid) begin
            c_tid <= TW'(req.task_id);
            c_lv  <= pri_sat;
            c_dly <= req.delay_ticks;
            sched <= acc_sched;
            bad   <= acc_bad;
            woke  <= '0;
            i     <= '0;
            k     <= '0;
            app   <= 1'b0;
            st    <= acc_st;
            if (!tid_bad) begin
              case (req.cmd)
                ptsu_pkg::CMD_WAKEUP: delayed_mask[TW'(req.task_id)] <= 1'b0;
                ptsu_pkg::CMD_LOCK: begin
                  if (lock_depth != ptsu_pkg::LOCK_MAX) begin
                    lock_depth <= lock_depth + 8'd1;
                  end
                end
                ptsu_pkg::CMD_UNLOCK: begin
                  if (lock_depth != 8'd0) begin
                    lock_depth <= lock_depth - 8'd1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ST_MR0: st <= ST_MR1;
        ST_MR1: begin
          lv     <= rd_lev;
          tt     <= c_tid;
          rm_ret <= ST_MR2;
          st     <= ST_RM0;
        end
        ST_MR2: begin
          lv              <= c_lv;
          tt              <= c_tid;
          is_ready[c_tid] <= 1'b1;
          ps_ret          <= ST_FIN0;
          st              <= ST_PH0;
        end
        ST_UR0: st <= ST_UR1;
        ST_UR1: begin
          lv              <= rd_lev;
          tt              <= c_tid;
          is_ready[c_tid] <= 1'b0;
          rm_ret          <= ST_FIN0;
          st              <= ST_RM0;
        end
        ST_DL0: begin
          delayed_mask[c_tid] <= 1'b1;
          if (delayed_mask[c_tid]) begin
            app <= 1'b1;
            st  <= ST_DR;
          end else begin
            dly_order[dly_num[TW-1:0]] <= c_tid;
            dly_num                    <= dly_num + CW'(1);
            st                         <= ST_FIN0;
          end
        end
        // compact the delay order, dropping c_tid (and appending it again for a repeated delay)
        ST_DR: begin
          if (i == dly_num) begin
            dly_num <= k + CW'(app);
            if (app) begin
              dly_order[k[TW-1:0]] <= c_tid;
            end
            st <= ST_FIN0;
          end else begin
            if (ord_i != c_tid) begin
              dly_order[k[TW-1:0]] <= ord_i;
              k <= k + CW'(1);
            end
            i <= i + CW'(1);
          end
        end
        ST_TK0: begin
          if (i == dly_num) begin
            dly_num <= k;
            st      <= ST_SL0;
          end else begin
            tt <= ord_i;
            st <= ST_TK1;
          end
        end
        ST_TK1: begin
          i <= i + CW'(1);
          if (dv == 32'd0) begin
            delayed_mask[tt] <= 1'b0;
            woke             <= woke + CW'(1);
            lv               <= rd_lev;
            rm_ret           <= ST_TKP;
            st               <= is_ready[tt] ? ST_RM0 : ST_TKP;
          end else begin
            dly_order[k[TW-1:0]] <= tt;
            k  <= k + CW'(1);
            st <= ST_TK0;
          end
        end
        ST_TKP: begin
          is_ready[tt] <= 1'b1;
          ps_ret       <= ST_TK0;
          st           <= ST_PH0;
        end
        ST_SL0: st <= ST_SL1;
        ST_SL1: begin
          slc_vld[running] <= 1'b1;
          tick_total       <= tick_total + 32'd1;
          sched            <= 1'b1;
          lv               <= rd_lev;
          st <= ((s1 == 8'd0) && ready_bitmap[rd_lev]) ? ST_RO0 : ST_FIN0;
        end
        ST_RO0: st <= ST_RO1;
        ST_RO1: begin
          tt     <= rd_head;
          rm_ret <= ST_RO2;
          st     <= ST_RM0;
        end
        ST_RO2: begin
          ps_ret <= ST_FIN0;
          st     <= ST_PT0;
        end
        // unlink tt from level lv
        ST_RM0: st <= ready_bitmap[lv] ? ST_RM1 : rm_ret;
        ST_RM1: begin
          cn <= rd_cnt;
          tl <= rd_tail;
          lt <= rd_link;
          p  <= rd_head;
          j  <= CW'(1);
          st <= (rd_head == tt) ? ST_RMDEC : ST_RMW;
        end
        ST_RMW: st <= (j >= cn) ? rm_ret : ST_RMW2;
        ST_RMW2: begin
          if (rd_link == tt) begin
            st <= ST_RMDEC;
          end else begin
            p  <= rd_link;
            j  <= j + CW'(1);
            st <= ST_RMW;
          end
        end
        ST_RMDEC: begin
          if (cn == CW'(1)) begin
            ready_bitmap[lv] <= 1'b0;
          end
          st <= rm_ret;
        end
        ST_PH0: st <= ST_PH1;
        ST_PH1: begin
          ready_bitmap[lv] <= 1'b1;
          st               <= ps_ret;
        end
        ST_PT0: st <= ST_PT1;
        ST_PT1: begin
          ready_bitmap[lv] <= 1'b1;
          st               <= ps_ret;
        end
        ST_FIN0: st <= ST_FIN1;
        ST_FIN1: begin
          if (sched_sw) begin
            running <= nt;
          end
          res.switch_now  <= sched_sw;
          res.next_task   <= 4'(nt);
          res.woke_count  <= 5'(woke);
          res.lock_level  <= lock_depth;
          res.bad_request <= bad;
          st              <= ST_OUT;
        end
        ST_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bitmap_ready: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> ((ready_bitmap == '0) == (is_ready == '0)))
    else $error("ready bitmap and ready flags disagree");
  a_delay_count: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> (32'($countones(delayed_mask)) == 32'(dly_num)))
    else $error("delay order length and delayed set disagree");
  a_switch_unlocked: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.switch_now) |-> (rsp.lock_level == 8'd0))
    else $error("switch reported while locked");
`endif

endmodule
